@@ hdl/edf_pkg.sv @@
// shared types, constants and helpers for the edf task scheduler
package edf_pkg;

    localparam int TASKS_DEF     = 8;
    localparam int TIME_BITS_DEF = 32;

    localparam int WORK_W    = 16;
    localparam int IN_IDX_W  = 3;
    localparam int OUT_IDX_W = 3;
    localparam int TICK_W    = 32;

    localparam int S_TDATA_W = 56;
    localparam int M_TDATA_W = 40;

    localparam int CFG_W = 3 * WORK_W;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } seq_state_t;

    typedef enum logic [1:0] {
        CH_NONE,
        CH_IDLE,
        CH_TASK
    } choice_t;

    typedef struct packed {
        logic ready;
        logic rd_en;
        logic proc_vld;
        logic publish;
    } seq_ctrl_t;

    function automatic int idx_width(input int n);
        return (n > 1) ? $clog2(n) : 1;
    endfunction

    function automatic int dyn_width(input int time_bits);
        return 2 * WORK_W + time_bits;
    endfunction

endpackage

@@ hdl/edf_ram.sv @@
// generic single write port ram with registered read
module edf_ram #(
    parameter int WIDTH  = 16,
    parameter int DEPTH  = 8,
    parameter int ADDR_W = 3
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ hdl/edf_pe.sv @@
// shared release update and wrap-aware deadline compare unit
module edf_pe #(
    parameter int TIME_BITS = 32
) (
    input  logic [edf_pkg::CFG_W-1:0]                    cfg_word,
    input  logic                                         cfg_vld,
    input  logic [edf_pkg::dyn_width(TIME_BITS)-1:0]     dyn_word,
    input  logic                                         dyn_vld,
    input  logic [TIME_BITS-1:0]                         now,
    input  logic                                         best_found,
    input  logic [TIME_BITS-1:0]                         best_ad,
    output logic [edf_pkg::dyn_width(TIME_BITS)-1:0]     dyn_new,
    output logic                                         take
);
    import edf_pkg::*;

    logic [WORK_W-1:0]    cap;
    logic [WORK_W-1:0]    rel;
    logic [WORK_W-1:0]    period;
    logic [WORK_W-1:0]    rw;
    logic [WORK_W-1:0]    cd;
    logic [TIME_BITS-1:0] ad;
    logic [WORK_W-1:0]    rw_n;
    logic [WORK_W-1:0]    cd_n;
    logic [TIME_BITS-1:0] ad_n;
    logic [TIME_BITS-1:0] diff;

    always_comb begin
        cap    = cfg_vld ? cfg_word[WORK_W-1:0]          : '0;
        rel    = cfg_vld ? cfg_word[2*WORK_W-1:WORK_W]   : '0;
        period = cfg_vld ? cfg_word[3*WORK_W-1:2*WORK_W] : '0;
        rw     = dyn_vld ? dyn_word[WORK_W-1:0]          : '0;
        cd     = dyn_vld ? dyn_word[2*WORK_W-1:WORK_W]   : '0;
        ad     = dyn_vld ? dyn_word[2*WORK_W+TIME_BITS-1:2*WORK_W] : '0;

        rw_n = rw;
        cd_n = cd;
        ad_n = ad;
        if (period != '0) begin
            if (cd == '0) begin
                rw_n = cap;
                ad_n = now + TIME_BITS'(rel);
                cd_n = period - WORK_W'(1);
            end else begin
                cd_n = cd - WORK_W'(1);
            end
        end

        // earlier when the wrapped difference is negative
        diff    = ad_n - best_ad;
        take    = (rw_n != '0) && (!best_found || diff[TIME_BITS-1]);
        dyn_new = {ad_n, cd_n, rw_n};
    end

endmodule

@@ hdl/edf_seq.sv @@
// sequencer that walks the task entries once per tick
module edf_seq #(
    parameter int TASKS = 8
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  tick_start,
    input  logic                                  out_free,
    output edf_pkg::seq_ctrl_t                    ctrl,
    output logic [edf_pkg::idx_width(TASKS)-1:0]  rd_addr,
    output logic [edf_pkg::idx_width(TASKS)-1:0]  proc_idx
);
    import edf_pkg::*;

    localparam int IDX_W = idx_width(TASKS);
    localparam int CNT_W = $clog2(TASKS + 1);

    seq_state_t       state_reg, state_next;
    logic [CNT_W-1:0] rd_cnt_reg, rd_cnt_next;
    logic             pipe_vld_reg, pipe_vld_next;
    logic [IDX_W-1:0] proc_idx_reg, proc_idx_next;
    logic             scan_end;

    assign scan_end = (rd_cnt_reg == CNT_W'(TASKS));
    assign rd_addr  = rd_cnt_reg[IDX_W-1:0];
    assign proc_idx = proc_idx_reg;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (tick_start) begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (scan_end) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        ctrl          = '0;
        ctrl.proc_vld = pipe_vld_reg;
        case (state_reg)
            ST_IDLE: ctrl.ready   = 1'b1;
            ST_SCAN: ctrl.rd_en   = !scan_end;
            ST_DONE: ctrl.publish = out_free;
            default: ctrl         = '0;
        endcase
    end

    always_comb begin
        rd_cnt_next   = rd_cnt_reg;
        if (state_reg == ST_IDLE) begin
            rd_cnt_next = '0;
        end else if (ctrl.rd_en) begin
            rd_cnt_next = rd_cnt_reg + CNT_W'(1);
        end
        pipe_vld_next = ctrl.rd_en;
        proc_idx_next = ctrl.rd_en ? rd_addr : proc_idx_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            rd_cnt_reg   <= '0;
            pipe_vld_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            rd_cnt_reg   <= rd_cnt_next;
            pipe_vld_reg <= pipe_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        proc_idx_reg <= proc_idx_next;
    end

endmodule

@@ hdl/edf_task_scheduler.sv @@
// top level of the earliest deadline first task scheduler
//
// A load transfer restarts the schedule. A tick transfer is accepted, then
// the task entries are streamed out of the configuration and job memories
// one entry a cycle through the single release and deadline compare unit,
// and finally the chosen task's work is written back and the result is
// presented; the block is not ready during that time and a stalled result
// holds it longer.
// Memory contents after reset are masked by per-entry valid bits, so no
// clearing pass is needed.
module edf_task_scheduler #(
    parameter int TASKS     = edf_pkg::TASKS_DEF,
    parameter int TIME_BITS = edf_pkg::TIME_BITS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // task_index, capacity, rel_deadline, period
    input  logic [edf_pkg::S_TDATA_W-1:0]   s_tdata,
    // kind
    input  logic                            s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // running_task, switched, tick_time
    output logic [edf_pkg::M_TDATA_W-1:0]   m_tdata,
    // idle
    output logic                            m_tuser
);
    import edf_pkg::*;

    localparam int IDX_W = idx_width(TASKS);
    localparam int DYN_W = dyn_width(TIME_BITS);

    seq_ctrl_t            ctrl;
    logic [IDX_W-1:0]     rd_addr;
    logic [IDX_W-1:0]     proc_idx;
    logic                 tick_start;
    logic                 load_acc;
    logic                 out_free;
    logic [6:0]           load_idx;
    logic                 load_ok;

    logic [CFG_W-1:0]     cfg_rdata;
    logic [DYN_W-1:0]     dyn_rdata;
    logic [DYN_W-1:0]     dyn_new;
    logic                 take;
    logic                 dyn_we;
    logic [IDX_W-1:0]     dyn_waddr;
    logic [DYN_W-1:0]     dyn_wdata;

    logic [TASKS-1:0]     cfg_vld_reg;
    logic [TASKS-1:0]     dyn_vld_reg;
    logic [TIME_BITS-1:0] time_reg;
    choice_t              prev_kind_reg;
    logic [IDX_W-1:0]     prev_task_reg;
    logic                 found_reg;
    logic [IDX_W-1:0]     best_idx_reg;
    logic [TIME_BITS-1:0] best_ad_reg;
    logic [WORK_W-1:0]    best_rw_reg;
    logic [WORK_W-1:0]    best_cd_reg;
    logic                 m_tvalid_reg;
    logic [M_TDATA_W-1:0] m_tdata_reg;
    logic                 m_tuser_reg;

    choice_t              kind_now;
    logic                 switched;
    logic [63:0]          sel_wide;
    logic [63:0]          time_wide;

    assign out_free   = !m_tvalid_reg || m_tready;
    assign s_tready   = ctrl.ready;
    assign tick_start = s_tvalid && s_tready && !s_tuser;
    assign load_acc   = s_tvalid && s_tready && s_tuser;
    assign load_idx   = 7'(s_tdata[IN_IDX_W-1:0]);
    assign load_ok    = load_acc && (load_idx < 7'(TASKS));

    edf_seq #(
        .TASKS (TASKS)
    ) u_seq (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .tick_start (tick_start),
        .out_free   (out_free),
        .ctrl       (ctrl),
        .rd_addr    (rd_addr),
        .proc_idx   (proc_idx)
    );

    edf_ram #(
        .WIDTH  (CFG_W),
        .DEPTH  (TASKS),
        .ADDR_W (IDX_W)
    ) u_cfg_ram (
        .aclk  (aclk),
        .we    (load_ok),
        .waddr (load_idx[IDX_W-1:0]),
        .wdata (s_tdata[IN_IDX_W+CFG_W-1:IN_IDX_W]),
        .re    (ctrl.rd_en),
        .raddr (rd_addr),
        .rdata (cfg_rdata)
    );

    // scan write-back and final work decrement never share a cycle
    assign dyn_we    = ctrl.proc_vld || (ctrl.publish && found_reg);
    assign dyn_waddr = ctrl.proc_vld ? proc_idx : best_idx_reg;
    assign dyn_wdata = ctrl.proc_vld ? dyn_new
                     : {best_ad_reg, best_cd_reg, best_rw_reg - WORK_W'(1)};

    edf_ram #(
        .WIDTH  (DYN_W),
        .DEPTH  (TASKS),
        .ADDR_W (IDX_W)
    ) u_dyn_ram (
        .aclk  (aclk),
        .we    (dyn_we),
        .waddr (dyn_waddr),
        .wdata (dyn_wdata),
        .re    (ctrl.rd_en),
        .raddr (rd_addr),
        .rdata (dyn_rdata)
    );

    edf_pe #(
        .TIME_BITS (TIME_BITS)
    ) u_pe (
        .cfg_word   (cfg_rdata),
        .cfg_vld    (cfg_vld_reg[proc_idx]),
        .dyn_word   (dyn_rdata),
        .dyn_vld    (dyn_vld_reg[proc_idx]),
        .now        (time_reg),
        .best_found (found_reg),
        .best_ad    (best_ad_reg),
        .dyn_new    (dyn_new),
        .take       (take)
    );

    assign kind_now  = found_reg ? CH_TASK : CH_IDLE;
    assign switched  = (kind_now != prev_kind_reg)
                     || (found_reg && (best_idx_reg != prev_task_reg));
    assign sel_wide  = found_reg ? 64'(best_idx_reg) : 64'd0;
    assign time_wide = 64'(time_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_vld_reg   <= '0;
            dyn_vld_reg   <= '0;
            time_reg      <= '0;
            prev_kind_reg <= CH_NONE;
            prev_task_reg <= '0;
            found_reg     <= 1'b0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            if (load_ok) begin
                cfg_vld_reg[load_idx[IDX_W-1:0]] <= 1'b1;
                dyn_vld_reg   <= '0;
                time_reg      <= '0;
                prev_kind_reg <= CH_NONE;
                prev_task_reg <= '0;
            end
            if (ctrl.proc_vld) begin
                dyn_vld_reg[proc_idx] <= 1'b1;
            end
            if (tick_start) begin
                found_reg <= 1'b0;
            end else if (ctrl.proc_vld && take) begin
                found_reg <= 1'b1;
            end
            if (ctrl.publish) begin
                time_reg      <= time_reg + TIME_BITS'(1);
                prev_kind_reg <= kind_now;
                prev_task_reg <= found_reg ? best_idx_reg : '0;
                m_tvalid_reg  <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg  <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.proc_vld && take) begin
            best_idx_reg <= proc_idx;
            best_rw_reg  <= dyn_new[WORK_W-1:0];
            best_cd_reg  <= dyn_new[2*WORK_W-1:WORK_W];
            best_ad_reg  <= dyn_new[DYN_W-1:2*WORK_W];
        end
        if (ctrl.publish) begin
            m_tdata_reg <= {4'd0, time_wide[TICK_W-1:0], switched, sel_wide[OUT_IDX_W-1:0]};
            m_tuser_reg <= !found_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    a_no_scan_when_ready : assert property (
        @(posedge aclk) disable iff (!aresetn)
        ctrl.proc_vld |-> !ctrl.ready
    ) else $error("task entry processed while accepting transfers");

    a_no_write_clash : assert property (
        @(posedge aclk) disable iff (!aresetn)
        !(ctrl.proc_vld && ctrl.publish)
    ) else $error("scan write-back and work decrement in the same cycle");

    a_time_advance : assert property (
        @(posedge aclk) disable iff (!aresetn)
        ctrl.publish |=> (time_reg == $past(time_reg) + TIME_BITS'(1))
    ) else $error("tick time did not advance after a result");

    a_load_restart : assert property (
        @(posedge aclk) disable iff (!aresetn)
        load_ok |=> (time_reg == '0) && (prev_kind_reg == CH_NONE) && (dyn_vld_reg == '0)
    ) else $error("schedule not restarted after a load");

    a_publish_output_free : assert property (
        @(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && !m_tready) |-> !ctrl.publish
    ) else $error("result overwritten while still waiting");

endmodule
